@@ hw/rtl/wht_pkg.sv @@
// Shared types and constants for the window hit-test / move-to-front block.
// Used by wht_order, wht_ctrl and the top level; depends on nothing else.
package wht_pkg;

  localparam int MAX_WINDOWS = 16;
  localparam int IDX_W       = $clog2(MAX_WINDOWS);      // stack position / slot index
  localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);  // window count, 0..MAX_WINDOWS
  localparam int SLOT_W      = 4;                        // slot / position field width
  localparam int ID_W        = 8;
  localparam int COORD_W     = 10;
  localparam int WCOUNT_W    = 5;
  localparam int CMP_W       = CNT_W + SLOT_W;           // common width for range checks

  localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = WCOUNT_W'(16);
  localparam logic [COORD_W-1:0]  POINT_LIMIT  = COORD_W'(1000);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLICK = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_HIT      = 3'd1,
    STAT_MISS     = 3'd2,
    STAT_BAD_RECT = 3'd3,
    STAT_RANGE    = 3'd4,
    STAT_POINT    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_TOP,
    S_DONE
  } state_t;

  // one input word
  typedef struct packed {
    logic [1:0]         opcode;
    logic [SLOT_W-1:0]  slot;
    logic [SLOT_W-1:0]  position;
    logic [ID_W-1:0]    win_id;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } item_t;

  // one result word
  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] hit_slot;
    logic [ID_W-1:0]   hit_id;
    logic [SLOT_W-1:0] order_slot;
    logic [ID_W-1:0]   order_id;
  } res_t;

  // rectangle store entry, indexed by slot
  typedef struct packed {
    logic [ID_W-1:0]    win_id;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
  } rect_t;

  localparam int RECT_W = $bits(rect_t);

  // access to the stack order memory
  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } ord_req_t;

  // access to the rectangle memory
  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    rect_t            wr_data;
  } rect_req_t;

endpackage

@@ hw/rtl/wht_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// A read of the address being written returns the old contents. No dependencies.
module wht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/wht_order.sv @@
// Stack order store: position -> slot, one RAM plus a valid bit per position.
// A position never written reads as its own index. Uses wht_pkg and wht_ram.
module wht_order (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wht_pkg::ord_req_t       req,
  output logic [wht_pkg::IDX_W-1:0] q
);

  logic [wht_pkg::MAX_WINDOWS-1:0] vld_r;
  logic [wht_pkg::IDX_W-1:0]       rd_addr_r;
  logic                            rd_vld_r;
  logic [wht_pkg::IDX_W-1:0]       ram_q;

  wht_ram #(
    .WIDTH (wht_pkg::IDX_W),
    .DEPTH (wht_pkg::MAX_WINDOWS)
  ) u_ram (
    .clk   (clk),
    .we    (req.we),
    .waddr (req.wr_addr),
    .wdata (req.wr_data),
    .raddr (req.rd_addr),
    .rdata (ram_q)
  );

  // per-position written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.we) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // sample flag and address alongside the RAM read
  always_ff @(posedge clk) begin
    rd_addr_r <= req.rd_addr;
    rd_vld_r  <= vld_r[req.rd_addr];
  end

  // untouched positions hold the identity order
  assign q = rd_vld_r ? ram_q : rd_addr_r;

endmodule

@@ hw/rtl/wht_ctrl.sv @@
// Sequencer: decodes each word, scans the stack, shifts it and builds the result.
// Owns the loaded flags and the output register. Uses wht_pkg.
module wht_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  wht_pkg::item_t             in_item,
  input  logic [wht_pkg::CNT_W-1:0]  n,
  output wht_pkg::ord_req_t          ord_req,
  input  logic [wht_pkg::IDX_W-1:0]  ord_q,
  output wht_pkg::rect_req_t         rect_req,
  input  wht_pkg::rect_t             rect_q,
  output logic                       out_valid,
  input  logic                       out_stall,
  output wht_pkg::res_t              out_res
);

  wht_pkg::state_t state_r, state_nxt;
  wht_pkg::item_t  item_r, item_nxt;
  wht_pkg::res_t   res_r, res_nxt;
  wht_pkg::res_t   out_r, out_nxt;
  logic            out_v_r, out_v_nxt;

  logic [wht_pkg::MAX_WINDOWS-1:0] loaded_r, loaded_nxt;

  // scan pipeline: issue -> slot from order RAM -> rectangle from rect RAM
  logic [wht_pkg::CNT_W-1:0] iss_p_r, iss_p_nxt;
  logic [wht_pkg::CNT_W-1:0] iss_end_r, iss_end_nxt;
  logic                      p1_v_r, p1_v_nxt;
  logic [wht_pkg::IDX_W-1:0] p1_pos_r, p1_pos_nxt;
  logic                      p2_v_r, p2_v_nxt;
  logic [wht_pkg::IDX_W-1:0] p2_pos_r, p2_pos_nxt;
  logic [wht_pkg::IDX_W-1:0] p2_slot_r, p2_slot_nxt;
  logic                      p2_ld_r, p2_ld_nxt;

  // shift pass
  logic [wht_pkg::IDX_W-1:0] hit_slot_r, hit_slot_nxt;
  logic [wht_pkg::IDX_W-1:0] sh_k_r, sh_k_nxt;
  logic                      sh_go_r, sh_go_nxt;
  logic                      wb_v_r, wb_v_nxt;
  logic [wht_pkg::IDX_W-1:0] wb_addr_r, wb_addr_nxt;

  logic slot_oor, pos_oor, rect_bad, point_bad, holds, p2_last;

  // decode helpers
  always_comb begin
    slot_oor  = wht_pkg::CMP_W'(item_r.slot) >= wht_pkg::CMP_W'(n);
    pos_oor   = wht_pkg::CMP_W'(item_r.position) >= wht_pkg::CMP_W'(n);
    rect_bad  = (item_r.left >= item_r.right) || (item_r.bottom >= item_r.top);
    point_bad = (item_r.point_x > wht_pkg::POINT_LIMIT) ||
                (item_r.point_y > wht_pkg::POINT_LIMIT);
    holds     = (item_r.point_x >= rect_q.left) && (item_r.point_x <= rect_q.right) &&
                (item_r.point_y >= rect_q.bottom) && (item_r.point_y <= rect_q.top);
    p2_last   = (wht_pkg::CNT_W'(p2_pos_r) + wht_pkg::CNT_W'(1)) == iss_end_r;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wht_pkg::S_IDLE;
      out_v_r  <= 1'b0;
      loaded_r <= '0;
      p1_v_r   <= 1'b0;
      p2_v_r   <= 1'b0;
      sh_go_r  <= 1'b0;
      wb_v_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      out_v_r  <= out_v_nxt;
      loaded_r <= loaded_nxt;
      p1_v_r   <= p1_v_nxt;
      p2_v_r   <= p2_v_nxt;
      sh_go_r  <= sh_go_nxt;
      wb_v_r   <= wb_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
    iss_p_r    <= iss_p_nxt;
    iss_end_r  <= iss_end_nxt;
    p1_pos_r   <= p1_pos_nxt;
    p2_pos_r   <= p2_pos_nxt;
    p2_slot_r  <= p2_slot_nxt;
    p2_ld_r    <= p2_ld_nxt;
    hit_slot_r <= hit_slot_nxt;
    sh_k_r     <= sh_k_nxt;
    wb_addr_r  <= wb_addr_nxt;
  end

  // next state and memory requests
  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    out_v_nxt    = out_v_r && out_stall;
    loaded_nxt   = loaded_r;
    iss_p_nxt    = iss_p_r;
    iss_end_nxt  = iss_end_r;
    p1_v_nxt     = 1'b0;
    p1_pos_nxt   = p1_pos_r;
    p2_v_nxt     = p1_v_r;
    p2_pos_nxt   = p1_pos_r;
    p2_slot_nxt  = ord_q;
    p2_ld_nxt    = loaded_r[ord_q];
    hit_slot_nxt = hit_slot_r;
    sh_k_nxt     = sh_k_r;
    sh_go_nxt    = sh_go_r;
    wb_v_nxt     = 1'b0;
    wb_addr_nxt  = wb_addr_r;

    ord_req          = '0;
    rect_req         = '0;
    rect_req.rd_addr = ord_q;
    rect_req.wr_addr = wht_pkg::IDX_W'(item_r.slot);
    rect_req.wr_data = '{win_id: item_r.win_id, left: item_r.left, bottom: item_r.bottom,
                         right: item_r.right, top: item_r.top};

    case (state_r)
      wht_pkg::S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_item;
          state_nxt = wht_pkg::S_EXEC;
        end
      end

      // decode, range checks, loads
      wht_pkg::S_EXEC: begin
        res_nxt        = '0;
        res_nxt.status = wht_pkg::STAT_DONE;
        state_nxt      = wht_pkg::S_DONE;
        case (item_r.opcode)
          wht_pkg::OP_LOAD: begin
            if (slot_oor) begin
              res_nxt.status = wht_pkg::STAT_RANGE;
            end else if (rect_bad) begin
              res_nxt.status = wht_pkg::STAT_BAD_RECT;
            end else begin
              rect_req.we = 1'b1;
              loaded_nxt[wht_pkg::IDX_W'(item_r.slot)] = 1'b1;
            end
          end
          wht_pkg::OP_CLICK: begin
            if (point_bad) begin
              res_nxt.status = wht_pkg::STAT_POINT;
            end else if (n == '0) begin
              res_nxt.status = wht_pkg::STAT_MISS;
            end else begin
              iss_p_nxt   = '0;
              iss_end_nxt = n;
              state_nxt   = wht_pkg::S_SCAN;
            end
          end
          wht_pkg::OP_READ: begin
            if (pos_oor) begin
              res_nxt.status = wht_pkg::STAT_RANGE;
            end else begin
              iss_p_nxt   = wht_pkg::CNT_W'(item_r.position);
              iss_end_nxt = wht_pkg::CNT_W'(item_r.position) + wht_pkg::CNT_W'(1);
              state_nxt   = wht_pkg::S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      // one stack position issued per cycle, checked when it reaches stage p2
      wht_pkg::S_SCAN: begin
        if (iss_p_r < iss_end_r) begin
          ord_req.rd_addr = wht_pkg::IDX_W'(iss_p_r);
          p1_v_nxt        = 1'b1;
          p1_pos_nxt      = wht_pkg::IDX_W'(iss_p_r);
          iss_p_nxt       = iss_p_r + wht_pkg::CNT_W'(1);
        end
        if (p2_v_r) begin
          if (item_r.opcode == wht_pkg::OP_READ) begin
            res_nxt.order_slot = wht_pkg::SLOT_W'(p2_slot_r);
            res_nxt.order_id   = rect_q.win_id;
            state_nxt          = wht_pkg::S_DONE;
          end else if (p2_ld_r && holds) begin
            res_nxt.status   = wht_pkg::STAT_HIT;
            res_nxt.hit_slot = wht_pkg::SLOT_W'(p2_slot_r);
            res_nxt.hit_id   = rect_q.win_id;
            hit_slot_nxt     = p2_slot_r;
            if (p2_pos_r == '0) begin
              state_nxt = wht_pkg::S_TOP;
            end else begin
              sh_k_nxt  = p2_pos_r - wht_pkg::IDX_W'(1);
              sh_go_nxt = 1'b1;
              state_nxt = wht_pkg::S_SHIFT;
            end
          end else if (p2_last) begin
            res_nxt.status = wht_pkg::STAT_MISS;
            state_nxt      = wht_pkg::S_DONE;
          end
        end
      end

      // move entries above the hit down by one, reading k-1 then writing k
      wht_pkg::S_SHIFT: begin
        if (sh_go_r) begin
          ord_req.rd_addr = sh_k_r;
          wb_v_nxt        = 1'b1;
          wb_addr_nxt     = sh_k_r + wht_pkg::IDX_W'(1);
          if (sh_k_r == '0) begin
            sh_go_nxt = 1'b0;
          end else begin
            sh_k_nxt = sh_k_r - wht_pkg::IDX_W'(1);
          end
        end
        if (wb_v_r) begin
          ord_req.we      = 1'b1;
          ord_req.wr_addr = wb_addr_r;
          ord_req.wr_data = ord_q;
          if (wb_addr_r == wht_pkg::IDX_W'(1)) begin
            state_nxt = wht_pkg::S_TOP;
          end
        end
      end

      // hit window goes to the top
      wht_pkg::S_TOP: begin
        ord_req.we      = 1'b1;
        ord_req.wr_addr = '0;
        ord_req.wr_data = hit_slot_r;
        state_nxt       = wht_pkg::S_DONE;
      end

      // hand the result to the output register once it is free
      wht_pkg::S_DONE: begin
        if (!out_v_r || !out_stall) begin
          out_nxt   = res_r;
          out_v_nxt = 1'b1;
          state_nxt = wht_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = wht_pkg::S_IDLE;
      end
    endcase

    // drain in-flight pipeline stages when leaving their step
    if (state_nxt != wht_pkg::S_SCAN) begin
      p1_v_nxt = 1'b0;
      p2_v_nxt = 1'b0;
    end
    if (state_nxt != wht_pkg::S_SHIFT) begin
      sh_go_nxt = 1'b0;
      wb_v_nxt  = 1'b0;
    end
  end

  assign in_stall  = (state_r != wht_pkg::S_IDLE);
  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

@@ hw/rtl/window_hit_test_move_to_front.sv @@
// Top level of the window stack with hit test and move to front.
// Holds the window count register and the rectangle store; uses wht_pkg,
// wht_ram, wht_order and wht_ctrl.
//
//   channel | direction | handshake           | word
//   in_     | input     | in_valid / in_stall   | opcode, slot, position, win_id, rect, point
//   out_    | output    | out_valid / out_stall | status, hit/order slot and id
//   cfg_    | input     | cfg_wr_en             | window count (5 bits)
//
// One word is worked on at a time; the order memory gives one position per
// cycle to the scan and to the shift. Reset clears control only; the order
// store starts as identity through per-position valid bits, so no clearing
// pass is needed. One result waits in the output register; a stalled output
// holds the sequencer in its last step.
module window_hit_test_move_to_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [wht_pkg::WCOUNT_W-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [wht_pkg::SLOT_W-1:0]    in_slot,
  input  logic [wht_pkg::SLOT_W-1:0]    in_position,
  input  logic [wht_pkg::ID_W-1:0]      in_win_id,
  input  logic [wht_pkg::COORD_W-1:0]   in_left,
  input  logic [wht_pkg::COORD_W-1:0]   in_bottom,
  input  logic [wht_pkg::COORD_W-1:0]   in_right,
  input  logic [wht_pkg::COORD_W-1:0]   in_top,
  input  logic [wht_pkg::COORD_W-1:0]   in_point_x,
  input  logic [wht_pkg::COORD_W-1:0]   in_point_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [wht_pkg::SLOT_W-1:0]    out_hit_slot,
  output logic [wht_pkg::ID_W-1:0]      out_hit_id,
  output logic [wht_pkg::SLOT_W-1:0]    out_order_slot,
  output logic [wht_pkg::ID_W-1:0]      out_order_id
);

  logic [wht_pkg::WCOUNT_W-1:0] wcount_r;
  logic [wht_pkg::CNT_W-1:0]    n;
  wht_pkg::item_t               in_item;
  wht_pkg::res_t                res;
  wht_pkg::ord_req_t            ord_req;
  logic [wht_pkg::IDX_W-1:0]    ord_q;
  wht_pkg::rect_req_t           rect_req;
  logic [wht_pkg::RECT_W-1:0]   rect_rdata;
  wht_pkg::rect_t               rect_q;

  // window count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcount_r <= wht_pkg::WCOUNT_RESET;
    end else if (cfg_wr_en) begin
      wcount_r <= cfg_wr_data;
    end
  end

  // effective count, limited to the stack depth
  assign n = (32'(wcount_r) > wht_pkg::MAX_WINDOWS) ? wht_pkg::CNT_W'(wht_pkg::MAX_WINDOWS)
                                                    : wht_pkg::CNT_W'(wcount_r);

  // pack the input word
  assign in_item = '{opcode: in_opcode, slot: in_slot, position: in_position,
                     win_id: in_win_id, left: in_left, bottom: in_bottom,
                     right: in_right, top: in_top, point_x: in_point_x,
                     point_y: in_point_y};

  wht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .n         (n),
    .ord_req   (ord_req),
    .ord_q     (ord_q),
    .rect_req  (rect_req),
    .rect_q    (rect_q),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  wht_order u_order (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ord_req),
    .q     (ord_q)
  );

  // rectangle and id per slot
  wht_ram #(
    .WIDTH (wht_pkg::RECT_W),
    .DEPTH (wht_pkg::MAX_WINDOWS)
  ) u_rect_ram (
    .clk   (clk),
    .we    (rect_req.we),
    .waddr (rect_req.wr_addr),
    .wdata (rect_req.wr_data),
    .raddr (rect_req.rd_addr),
    .rdata (rect_rdata)
  );

  assign rect_q = wht_pkg::rect_t'(rect_rdata);

  // unpack the result word
  assign out_status     = res.status;
  assign out_hit_slot   = res.hit_slot;
  assign out_hit_id     = res.hit_id;
  assign out_order_slot = res.order_slot;
  assign out_order_id   = res.order_id;

  // rectangle writes only go to slots in use
  assert property (@(posedge clk) disable iff (!rst_n)
    rect_req.we |-> (wht_pkg::CMP_W'(rect_req.wr_addr) < wht_pkg::CMP_W'(n)))
    else $error("rectangle write to slot beyond window count");

  // order writes stay inside the scanned part of the stack
  assert property (@(posedge clk) disable iff (!rst_n)
    ord_req.we |-> (wht_pkg::CMP_W'(ord_req.wr_addr) < wht_pkg::CMP_W'(n)))
    else $error("stack order write beyond window count");

  // memories are only written while a word is being worked on
  assert property (@(posedge clk) disable iff (!rst_n)
    (ord_req.we || rect_req.we) |-> in_stall)
    else $error("memory write while idle");

  // an accepted word always occupies the sequencer for the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accept");

endmodule
